FILE: rtl/load_cell_adc_serial_reader_unit_assert.svh
// Assertion macros shared by the load cell reader modules.
`ifndef LOAD_CELL_ADC_SERIAL_READER_UNIT_ASSERT_SVH
`define LOAD_CELL_ADC_SERIAL_READER_UNIT_ASSERT_SVH

// Condition must hold in the same cycle as the trigger.
`define LCR_AST_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("load cell reader: same-cycle check failed");

// Condition must hold in the cycle after the trigger.
`define LCR_AST_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("load cell reader: next-cycle check failed");

`endif

FILE: rtl/lcr_pkg.sv
// Shared types, codes and constants of the load cell reader.
package lcr_pkg;

  localparam int SAMPLE_BITS_DEF = 24;
  localparam int SUM_W           = 32;
  localparam int CNT_W           = 8;
  localparam int GAIN_W          = 2;
  localparam int AVG_W           = 24;
  localparam int WEIGHT_W        = 32;
  localparam int CFG_ADDR_W      = 2;
  localparam int CFG_DATA_W      = 32;
  localparam int IN_TDATA_W      = 8;
  localparam int IN_TUSER_W      = 2;
  localparam int OUT_TDATA_W     = 64;
  localparam int STEPS           = 32;
  localparam int STEP_W          = 5;

  localparam logic [STEP_W-1:0]   LAST_STEP    = STEP_W'(STEPS - 1);
  localparam logic [GAIN_W-1:0]   GAIN_RESET   = GAIN_W'(1);
  localparam logic [CNT_W-1:0]    COUNT_RESET  = CNT_W'(1);
  localparam logic [SUM_W-1:0]    OFFSET_RESET = '0;
  localparam logic [SUM_W-1:0]    SCALE_RESET  = 32'h0001_0000;

  typedef enum logic [1:0] {
    REQ_TICK,
    REQ_FETCH,
    REQ_PWR_DOWN,
    REQ_PWR_UP
  } req_t;

  typedef enum logic [1:0] {
    CFG_GAIN,
    CFG_COUNT,
    CFG_OFFSET,
    CFG_SCALE
  } cfg_reg_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_CHECK,
    PH_BIT_HI,
    PH_BIT_LO,
    PH_GAIN_HI,
    PH_GAIN_LO
  } phase_t;

  typedef enum logic {
    CTL_IDLE,
    CTL_CALC
  } ctl_state_t;

  typedef enum logic [3:0] {
    AR_IDLE,
    AR_ABS_SUM,
    AR_DIV,
    AR_SIGN_AVG,
    AR_SUB_OFS,
    AR_ABS_DIFF,
    AR_ABS_SCALE,
    AR_MUL,
    AR_SIGN_PROD
  } ar_state_t;

  // Status of one tick, valid in the cycle the word is accepted.
  typedef struct packed {
    logic sck;
    logic busy;
    logic done;
    logic err;
    logic fin;
  } tick_res_t;

  // Finished average and weight from the arithmetic unit.
  typedef struct packed {
    logic                done;
    logic [AVG_W-1:0]    avg;
    logic [WEIGHT_W-1:0] weight;
  } ar_res_t;

endpackage

FILE: rtl/lcr_arith.sv
// Shared adder unit: signed average by restoring division, then offset and Q16.16 scaling.
`include "load_cell_adc_serial_reader_unit_assert.svh"

module lcr_arith (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [lcr_pkg::SUM_W-1:0]     sum,
  input  logic [lcr_pkg::CNT_W-1:0]     count,
  input  logic [lcr_pkg::SUM_W-1:0]     offset,
  input  logic [lcr_pkg::SUM_W-1:0]     scale,
  output lcr_pkg::ar_res_t              res
);

  localparam int W = lcr_pkg::SUM_W;

  lcr_pkg::ar_state_t          state_r, state_nxt;
  logic [lcr_pkg::STEP_W-1:0]  step_r, step_nxt;
  logic [W-1:0]                hi_r, hi_nxt;
  logic [W-1:0]                lo_r, lo_nxt;
  logic [W-1:0]                mc_r, mc_nxt;
  logic [W-1:0]                avg_r, avg_nxt;
  logic [W-1:0]                weight_r, weight_nxt;
  logic                        neg_r, neg_nxt;
  logic                        done_r, done_nxt;

  logic [W:0]                  add_a, add_b;
  logic                        add_cin;
  logic [W+1:0]                add_sum;
  logic                        add_carry;
  logic [W:0]                  mul_sel;
  logic [W-1:0]                prod_mid;

  // The one adder that every step of the sequence goes through.
  assign add_sum   = {1'b0, add_a} + {1'b0, add_b} + (W+2)'(add_cin);
  assign add_carry = add_sum[W+1];
  assign prod_mid  = {hi_r[15:0], lo_r[W-1:16]};

  // Adder operand selection per step.
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_cin = 1'b0;
    case (state_r)
      lcr_pkg::AR_ABS_SUM: begin
        add_b   = {1'b0, sum[W-1] ? ~sum : sum};
        add_cin = sum[W-1];
      end
      lcr_pkg::AR_DIV: begin
        add_a   = {hi_r, lo_r[W-1]};
        add_b   = ~{(W+1-lcr_pkg::CNT_W)'(0), count};
        add_cin = 1'b1;
      end
      lcr_pkg::AR_SIGN_AVG: begin
        add_b   = {1'b0, neg_r ? ~lo_r : lo_r};
        add_cin = neg_r;
      end
      lcr_pkg::AR_SUB_OFS: begin
        add_a   = {1'b0, avg_r};
        add_b   = {1'b0, ~offset};
        add_cin = 1'b1;
      end
      lcr_pkg::AR_ABS_DIFF: begin
        add_b   = {1'b0, mc_r[W-1] ? ~mc_r : mc_r};
        add_cin = mc_r[W-1];
      end
      lcr_pkg::AR_ABS_SCALE: begin
        add_b   = {1'b0, scale[W-1] ? ~scale : scale};
        add_cin = scale[W-1];
      end
      lcr_pkg::AR_MUL: begin
        add_a = {1'b0, hi_r};
        add_b = {1'b0, mc_r};
      end
      lcr_pkg::AR_SIGN_PROD: begin
        // Negating the 64-bit product only needs bits 47:16 and a carry from below.
        add_b   = {1'b0, neg_r ? ~prod_mid : prod_mid};
        add_cin = neg_r && (lo_r[15:0] == '0);
      end
      default: begin
        add_a = '0;
      end
    endcase
  end

  assign mul_sel = lo_r[0] ? add_sum[W:0] : {1'b0, hi_r};

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lcr_pkg::AR_IDLE:      if (start) state_nxt = lcr_pkg::AR_ABS_SUM;
      lcr_pkg::AR_ABS_SUM:   state_nxt = lcr_pkg::AR_DIV;
      lcr_pkg::AR_DIV:       if (step_r == lcr_pkg::LAST_STEP) state_nxt = lcr_pkg::AR_SIGN_AVG;
      lcr_pkg::AR_SIGN_AVG:  state_nxt = lcr_pkg::AR_SUB_OFS;
      lcr_pkg::AR_SUB_OFS:   state_nxt = lcr_pkg::AR_ABS_DIFF;
      lcr_pkg::AR_ABS_DIFF:  state_nxt = lcr_pkg::AR_ABS_SCALE;
      lcr_pkg::AR_ABS_SCALE: state_nxt = lcr_pkg::AR_MUL;
      lcr_pkg::AR_MUL:       if (step_r == lcr_pkg::LAST_STEP) state_nxt = lcr_pkg::AR_SIGN_PROD;
      lcr_pkg::AR_SIGN_PROD: state_nxt = lcr_pkg::AR_IDLE;
      default:               state_nxt = lcr_pkg::AR_IDLE;
    endcase
  end

  // Datapath updates per step.
  always_comb begin
    step_nxt   = step_r;
    hi_nxt     = hi_r;
    lo_nxt     = lo_r;
    mc_nxt     = mc_r;
    avg_nxt    = avg_r;
    weight_nxt = weight_r;
    neg_nxt    = neg_r;
    done_nxt   = 1'b0;
    case (state_r)
      lcr_pkg::AR_ABS_SUM: begin
        lo_nxt   = add_sum[W-1:0];
        hi_nxt   = '0;
        neg_nxt  = sum[W-1];
        step_nxt = '0;
      end
      lcr_pkg::AR_DIV: begin
        // Keep the trial difference when the shifted remainder covers the divisor.
        hi_nxt   = add_carry ? add_sum[W-1:0] : add_a[W-1:0];
        lo_nxt   = {lo_r[W-2:0], add_carry};
        step_nxt = step_r + 1'b1;
      end
      lcr_pkg::AR_SIGN_AVG: begin
        avg_nxt = add_sum[W-1:0];
      end
      lcr_pkg::AR_SUB_OFS: begin
        mc_nxt = add_sum[W-1:0];
      end
      lcr_pkg::AR_ABS_DIFF: begin
        mc_nxt  = add_sum[W-1:0];
        neg_nxt = mc_r[W-1] ^ scale[W-1];
      end
      lcr_pkg::AR_ABS_SCALE: begin
        lo_nxt   = add_sum[W-1:0];
        hi_nxt   = '0;
        step_nxt = '0;
      end
      lcr_pkg::AR_MUL: begin
        // Shift-add multiply: product accumulates in hi, multiplier drains from lo.
        hi_nxt   = mul_sel[W:1];
        lo_nxt   = {mul_sel[0], lo_r[W-1:1]};
        step_nxt = step_r + 1'b1;
      end
      lcr_pkg::AR_SIGN_PROD: begin
        weight_nxt = add_sum[W-1:0];
        done_nxt   = 1'b1;
      end
      default: begin
        done_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lcr_pkg::AR_IDLE;
      step_r  <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hi_r     <= hi_nxt;
    lo_r     <= lo_nxt;
    mc_r     <= mc_nxt;
    avg_r    <= avg_nxt;
    weight_r <= weight_nxt;
    neg_r    <= neg_nxt;
  end

  assign res.done   = done_r;
  assign res.avg    = avg_r[lcr_pkg::AVG_W-1:0];
  assign res.weight = weight_r;

  `LCR_AST_NOW(a_start_when_idle, start, state_r == lcr_pkg::AR_IDLE)

endmodule

FILE: rtl/lcr_tick.sv
// Per-tick serial protocol sequencer: power down and up, ready check, data bits, gain pulses, summing.
`include "load_cell_adc_serial_reader_unit_assert.svh"

module lcr_tick #(
  parameter int SAMPLE_BITS = lcr_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic [1:0]                    req_type,
  input  logic                          dout_level,
  input  logic [lcr_pkg::GAIN_W-1:0]    gain,
  input  logic [lcr_pkg::CNT_W-1:0]     count,
  output lcr_pkg::tick_res_t            res,
  output logic [lcr_pkg::SUM_W-1:0]     running_sum
);

  localparam int BCNT_W = $clog2(SAMPLE_BITS + 1);
  localparam logic [BCNT_W-1:0] LAST_BIT = BCNT_W'(SAMPLE_BITS);

  lcr_pkg::phase_t               phase_r, phase_nxt;
  logic [BCNT_W-1:0]             bit_cnt_r, bit_cnt_nxt;
  logic [lcr_pkg::GAIN_W-1:0]    pulse_cnt_r, pulse_cnt_nxt;
  logic [lcr_pkg::CNT_W-1:0]     samples_r, samples_nxt;
  logic [SAMPLE_BITS-1:0]        shift_r, shift_nxt;
  logic [lcr_pkg::SUM_W-1:0]     sum_r, sum_nxt;
  logic                          pd_r, pd_nxt;

  lcr_pkg::req_t                 req;
  logic [BCNT_W-1:0]             bit_inc;
  logic [lcr_pkg::GAIN_W-1:0]    pulse_inc;
  logic [lcr_pkg::CNT_W-1:0]     samples_inc;
  logic                          bits_met, gain_met, count_met;
  logic                          start_fetch, check;
  logic [lcr_pkg::SUM_W-1:0]     sample_ext;

  assign req         = lcr_pkg::req_t'(req_type);
  assign bit_inc     = bit_cnt_r + 1'b1;
  assign pulse_inc   = pulse_cnt_r + 1'b1;
  assign samples_inc = samples_r + 1'b1;
  assign bits_met    = bit_inc >= LAST_BIT;
  assign gain_met    = (pulse_inc == '0) || (pulse_inc >= gain);
  assign count_met   = (samples_inc == '0) || (samples_inc >= count);
  assign start_fetch = (phase_r == lcr_pkg::PH_IDLE) && (req == lcr_pkg::REQ_FETCH) && !pd_r;
  assign check       = start_fetch || (phase_r == lcr_pkg::PH_CHECK);
  assign sample_ext  = lcr_pkg::SUM_W'($signed(shift_r));

  // Next phase; a ready check overrides the per-phase step.
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      lcr_pkg::PH_IDLE:    phase_nxt = lcr_pkg::PH_IDLE;
      lcr_pkg::PH_CHECK:   phase_nxt = lcr_pkg::PH_CHECK;
      lcr_pkg::PH_BIT_HI:  phase_nxt = lcr_pkg::PH_BIT_LO;
      lcr_pkg::PH_BIT_LO:  phase_nxt = bits_met ? lcr_pkg::PH_GAIN_HI : lcr_pkg::PH_BIT_HI;
      lcr_pkg::PH_GAIN_HI: phase_nxt = lcr_pkg::PH_GAIN_LO;
      lcr_pkg::PH_GAIN_LO: begin
        if (!gain_met) begin
          phase_nxt = lcr_pkg::PH_GAIN_HI;
        end else if (count_met) begin
          phase_nxt = lcr_pkg::PH_IDLE;
        end else begin
          phase_nxt = lcr_pkg::PH_CHECK;
        end
      end
      default:             phase_nxt = lcr_pkg::PH_IDLE;
    endcase
    if (check) begin
      phase_nxt = dout_level ? lcr_pkg::PH_IDLE : lcr_pkg::PH_BIT_HI;
    end
  end

  // Pin level, status flags and data register updates for this tick.
  always_comb begin
    bit_cnt_nxt   = bit_cnt_r;
    pulse_cnt_nxt = pulse_cnt_r;
    samples_nxt   = samples_r;
    shift_nxt     = shift_r;
    sum_nxt       = sum_r;
    pd_nxt        = pd_r;
    res           = '0;
    case (phase_r)
      lcr_pkg::PH_IDLE: begin
        if (req == lcr_pkg::REQ_PWR_DOWN) begin
          pd_nxt = 1'b1;
        end else if (req == lcr_pkg::REQ_PWR_UP) begin
          pd_nxt = 1'b0;
        end
        if (start_fetch) begin
          sum_nxt     = '0;
          samples_nxt = '0;
        end
        res.sck = pd_nxt;
      end
      lcr_pkg::PH_BIT_HI: begin
        res.sck = 1'b1;
      end
      lcr_pkg::PH_BIT_LO: begin
        // Bit sampled on the tick that drives the clock low, MSB first.
        shift_nxt   = {shift_r[SAMPLE_BITS-2:0], dout_level};
        bit_cnt_nxt = bit_inc;
        if (bits_met) begin
          pulse_cnt_nxt = '0;
        end
      end
      lcr_pkg::PH_GAIN_HI: begin
        res.sck = 1'b1;
      end
      lcr_pkg::PH_GAIN_LO: begin
        pulse_cnt_nxt = pulse_inc;
        if (gain_met) begin
          sum_nxt     = sum_r + sample_ext;
          samples_nxt = samples_inc;
          if (count_met) begin
            res.done = 1'b1;
            res.fin  = 1'b1;
          end
        end
      end
      default: begin
        res.sck = 1'b0;
      end
    endcase
    if (check) begin
      res.sck = 1'b0;
      if (dout_level) begin
        res.done = 1'b1;
        res.err  = 1'b1;
      end else begin
        shift_nxt   = '0;
        bit_cnt_nxt = '0;
      end
    end
    res.busy = (phase_nxt != lcr_pkg::PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= lcr_pkg::PH_IDLE;
      bit_cnt_r   <= '0;
      pulse_cnt_r <= '0;
      samples_r   <= '0;
      shift_r     <= '0;
      sum_r       <= '0;
      pd_r        <= 1'b0;
    end else if (accept) begin
      phase_r     <= phase_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      pulse_cnt_r <= pulse_cnt_nxt;
      samples_r   <= samples_nxt;
      shift_r     <= shift_nxt;
      sum_r       <= sum_nxt;
      pd_r        <= pd_nxt;
    end
  end

  assign running_sum = sum_r;

  `LCR_AST_NOW(a_fin_is_clean_done, accept && res.fin, res.done && !res.err && !res.busy)

endmodule

FILE: rtl/load_cell_adc_serial_reader_unit.sv
// Top level of the load cell ADC serial reader: ports, configuration and output register.
//
//   Channel  Direction  Accepted when              Contents
//   in_      slave      in_tvalid && in_tready     tdata: dout_level; tuser: req_type
//   out_     master     out_tvalid && out_tready   status flags, raw_average, weight
//   cfg_     write      cfg_wr_en                  index cfg_addr, value cfg_wdata
//
// The result of a tick word that does not end a fetch goes to the output register in
// the accepting cycle. For the tick that ends a successful fetch, the shared adder runs
// 32 division steps, 32 multiply steps and six sign and offset steps, and its registered
// done flag then loads the result word.
// Reset is synchronous, active low; in_tready stays low while the arithmetic runs and
// while an unread result word is stalled.
`include "load_cell_adc_serial_reader_unit_assert.svh"

module load_cell_adc_serial_reader_unit #(
  parameter int SAMPLE_BITS = lcr_pkg::SAMPLE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [0] dout_level, [7:1] zero
  input  logic [lcr_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [1:0] req_type
  input  logic [lcr_pkg::IN_TUSER_W-1:0]     in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [0] sck_level, [1] busy_res, [2] done_res, [3] not_ready_error,
  // [27:4] raw_average, [59:28] weight, [63:60] zero
  output logic [lcr_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                               cfg_wr_en,
  input  logic [lcr_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [lcr_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  logic [lcr_pkg::GAIN_W-1:0]      gain_r, gain_nxt;
  logic [lcr_pkg::CNT_W-1:0]       count_r, count_nxt;
  logic [lcr_pkg::SUM_W-1:0]       offset_r, offset_nxt;
  logic [lcr_pkg::SUM_W-1:0]       scale_r, scale_nxt;

  lcr_pkg::ctl_state_t             ctl_r, ctl_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [lcr_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic [lcr_pkg::AVG_W-1:0]       held_avg_r, held_avg_nxt;
  logic [lcr_pkg::WEIGHT_W-1:0]    held_weight_r, held_weight_nxt;

  logic                            in_accept;
  logic                            out_take;
  logic                            calc_start;
  lcr_pkg::tick_res_t              tick_res;
  lcr_pkg::ar_res_t                ar_res;
  logic [lcr_pkg::SUM_W-1:0]       running_sum;

  assign in_tready  = (ctl_r == lcr_pkg::CTL_IDLE) && (!out_valid_r || out_tready);
  assign in_accept  = in_tvalid && in_tready;
  assign out_take   = out_valid_r && out_tready;
  assign calc_start = in_accept && tick_res.fin;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  lcr_tick #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_tick (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_accept),
    .req_type    (in_tuser[1:0]),
    .dout_level  (in_tdata[0]),
    .gain        (gain_r),
    .count       (count_r),
    .res         (tick_res),
    .running_sum (running_sum)
  );

  lcr_arith u_arith (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (calc_start),
    .sum    (running_sum),
    .count  (count_r),
    .offset (offset_r),
    .scale  (scale_r),
    .res    (ar_res)
  );

  // Configuration writes; zero gain or zero count is ignored.
  always_comb begin
    gain_nxt   = gain_r;
    count_nxt  = count_r;
    offset_nxt = offset_r;
    scale_nxt  = scale_r;
    if (cfg_wr_en) begin
      case (lcr_pkg::cfg_reg_t'(cfg_addr))
        lcr_pkg::CFG_GAIN: begin
          if (cfg_wdata[lcr_pkg::GAIN_W-1:0] != '0) begin
            gain_nxt = cfg_wdata[lcr_pkg::GAIN_W-1:0];
          end
        end
        lcr_pkg::CFG_COUNT: begin
          if (cfg_wdata[lcr_pkg::CNT_W-1:0] != '0) begin
            count_nxt = cfg_wdata[lcr_pkg::CNT_W-1:0];
          end
        end
        lcr_pkg::CFG_OFFSET: offset_nxt = cfg_wdata[lcr_pkg::SUM_W-1:0];
        lcr_pkg::CFG_SCALE:  scale_nxt  = cfg_wdata[lcr_pkg::SUM_W-1:0];
        default:             gain_nxt   = gain_r;
      endcase
    end
  end

  // Control next state: wait in CALC while the shared unit finishes a fetch.
  always_comb begin
    ctl_nxt = ctl_r;
    case (ctl_r)
      lcr_pkg::CTL_IDLE: if (calc_start) ctl_nxt = lcr_pkg::CTL_CALC;
      lcr_pkg::CTL_CALC: if (ar_res.done) ctl_nxt = lcr_pkg::CTL_IDLE;
      default:           ctl_nxt = lcr_pkg::CTL_IDLE;
    endcase
  end

  // Output register and held results.
  always_comb begin
    out_valid_nxt   = out_valid_r && !out_tready;
    out_data_nxt    = out_data_r;
    held_avg_nxt    = held_avg_r;
    held_weight_nxt = held_weight_r;
    if (in_accept && !tick_res.fin) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {4'b0, held_weight_r, held_avg_r, tick_res.err, tick_res.done,
                       tick_res.busy, tick_res.sck};
    end
    if (ar_res.done) begin
      // A finished fetch drives the clock low and leaves the sequencer idle.
      held_avg_nxt    = ar_res.avg;
      held_weight_nxt = ar_res.weight;
      out_valid_nxt   = 1'b1;
      out_data_nxt    = {4'b0, ar_res.weight, ar_res.avg, 1'b0, 1'b1, 1'b0, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r        <= lcr_pkg::GAIN_RESET;
      count_r       <= lcr_pkg::COUNT_RESET;
      offset_r      <= lcr_pkg::OFFSET_RESET;
      scale_r       <= lcr_pkg::SCALE_RESET;
      ctl_r         <= lcr_pkg::CTL_IDLE;
      out_valid_r   <= 1'b0;
      held_avg_r    <= '0;
      held_weight_r <= '0;
    end else begin
      gain_r        <= gain_nxt;
      count_r       <= count_nxt;
      offset_r      <= offset_nxt;
      scale_r       <= scale_nxt;
      ctl_r         <= ctl_nxt;
      out_valid_r   <= out_valid_nxt;
      held_avg_r    <= held_avg_nxt;
      held_weight_r <= held_weight_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  `LCR_AST_NOW(a_calc_blocks_input, ctl_r == lcr_pkg::CTL_CALC, !in_tready && !out_valid_r)
  `LCR_AST_NEXT(a_fin_enters_calc, calc_start, ctl_r == lcr_pkg::CTL_CALC)
  `LCR_AST_NOW(a_result_only_in_calc, ar_res.done, ctl_r == lcr_pkg::CTL_CALC)

  // A taken word with no reload empties the register.
  `LCR_AST_NEXT(a_take_empties, out_take && !in_accept && !ar_res.done, !out_valid_r)

endmodule
